@@ src/rfrd_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rfrd_pkg: shared types and constants
// Item layouts, codes and controller/datapath signal groups for the
// rangefinder register device.
// ---------------------------------------------------------------------------
package rfrd_pkg;

  localparam int MAX_DISTANCE_CM_DEF = 2000;
  localparam int DIST_W       = 12;
  localparam int STR_W        = 16;
  localparam int TIME_W       = 32;
  localparam int MM_W         = 15;
  localparam int RECIP_W      = 16;
  localparam int PROD_W       = MM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_TEN = 16'd52429;
  localparam int RECIP_SHIFT  = 19;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 16;
  localparam int IDX_W        = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_STRENGTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UPDATE_PERIOD = 1'd1;
  localparam logic [STR_W-1:0]     MIN_STRENGTH_RST = 16'd0;
  localparam logic [STR_W-1:0]     UPDATE_PERIOD_RST = 16'd50;

  localparam logic [7:0] BURST_REGS   = 8'd4;
  localparam logic [7:0] REG_VERSION  = 8'h0C;
  localparam logic [7:0] VERSION_BYTE = 8'd1;
  localparam logic [STR_W-1:0] STR_FULL = 16'hFFFF;

  localparam logic [1:0] REG_DIST_LO = 2'd0;
  localparam logic [1:0] REG_DIST_HI = 2'd1;
  localparam logic [1:0] REG_STR_LO  = 2'd2;
  localparam logic [1:0] REG_STR_HI  = 2'd3;

  typedef enum logic [1:0] {
    MODE_MEAS   = 2'd0,
    MODE_SELECT = 2'd1,
    MODE_READ   = 2'd2,
    MODE_BAD    = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t              mode;
    logic [31:0]        now_ms;
    logic signed [31:0] range_mm;
    logic [7:0]         reg_select;
    logic [7:0]         read_count;
  } in_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       byte_valid;
    logic       status;
    logic       last;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_UPDATE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic calc;
    logic update;
    logic advance;
  } cmd_t;

  typedef struct packed {
    logic is_meas;
    logic is_last;
  } stat_t;

endpackage

@@ src/rfrd_ctrl.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rfrd_ctrl: transaction controller
// Sequences accept, measurement update and result words for one item.
// ---------------------------------------------------------------------------
module rfrd_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  rfrd_pkg::stat_t stat,
  output rfrd_pkg::cmd_t  cmd
);

  rfrd_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rfrd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rfrd_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = stat.is_meas ? rfrd_pkg::ST_CALC : rfrd_pkg::ST_EMIT;
        end
      end
      rfrd_pkg::ST_CALC:   state_nxt = rfrd_pkg::ST_UPDATE;
      rfrd_pkg::ST_UPDATE: state_nxt = rfrd_pkg::ST_IDLE;
      rfrd_pkg::ST_EMIT: begin
        if (out_ready && stat.is_last) begin
          state_nxt = rfrd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rfrd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    cmd         = '0;
    case (state_r)
      rfrd_pkg::ST_IDLE: begin
        in_ready = rst_n;
        cmd.load = in_valid && rst_n;
      end
      rfrd_pkg::ST_CALC:   cmd.calc = 1'b1;
      rfrd_pkg::ST_UPDATE: cmd.update = 1'b1;
      rfrd_pkg::ST_EMIT: begin
        out_valid   = 1'b1;
        cmd.advance = out_ready && !stat.is_last;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

@@ src/rfrd_dp.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rfrd_dp: sensor datapath
// Holds configuration, the item word, measurement state and the register
// pointer; forms result words of a burst one byte at a time.
// ---------------------------------------------------------------------------
module rfrd_dp #(
  parameter int MAX_DISTANCE_CM = rfrd_pkg::MAX_DISTANCE_CM_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [rfrd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rfrd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  rfrd_pkg::in_t                   in_data,
  input  rfrd_pkg::cmd_t                  cmd,
  output rfrd_pkg::stat_t                 stat,
  output rfrd_pkg::out_t                  out_data
);

  localparam int LIMIT_MM = MAX_DISTANCE_CM * 10;

  rfrd_pkg::in_t                     item_r;
  logic [rfrd_pkg::IDX_W-1:0]        idx_r;
  logic [7:0]                        pointer_r;
  logic [rfrd_pkg::DIST_W-1:0]       dist_r;
  logic [rfrd_pkg::STR_W-1:0]        str_r;
  logic [rfrd_pkg::TIME_W-1:0]       last_time_r;
  logic [rfrd_pkg::STR_W-1:0]        min_str_r;
  logic [rfrd_pkg::STR_W-1:0]        period_r;
  logic                              take_r;
  logic                              inrange_r;
  logic [rfrd_pkg::PROD_W-1:0]       prod_r;

  logic [rfrd_pkg::TIME_W-1:0]       elapsed;
  logic                              inrange;
  logic [rfrd_pkg::DIST_W-1:0]       cm;
  logic [rfrd_pkg::STR_W-1:0]        scaled;
  logic [rfrd_pkg::STR_W-1:0]        str_raw;
  logic [rfrd_pkg::STR_W-1:0]        str_new;
  logic [8:0]                        burst_end;
  logic [1:0]                        byte_addr;
  logic [7:0]                        reg_data;

  assign elapsed = item_r.now_ms - last_time_r;
  assign inrange = (item_r.range_mm > 32'sd0) &&
                   (item_r.range_mm <= 32'(LIMIT_MM));
  assign cm      = prod_r[rfrd_pkg::RECIP_SHIFT +: rfrd_pkg::DIST_W];
  assign scaled  = {cm, 4'b0000} + {2'b00, cm, 2'b00};
  assign str_raw = rfrd_pkg::STR_FULL - scaled;
  assign str_new = (str_raw < min_str_r) ? min_str_r : str_raw;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_str_r   <= rfrd_pkg::MIN_STRENGTH_RST;
      period_r    <= rfrd_pkg::UPDATE_PERIOD_RST;
      pointer_r   <= '0;
      dist_r      <= '0;
      str_r       <= '0;
      last_time_r <= '0;
      idx_r       <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          rfrd_pkg::CFG_MIN_STRENGTH:  min_str_r <= cfg_wdata;
          rfrd_pkg::CFG_UPDATE_PERIOD: period_r  <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.load) begin
        idx_r <= '0;
        if (in_data.mode == rfrd_pkg::MODE_SELECT) begin
          pointer_r <= in_data.reg_select;
        end
      end
      if (cmd.advance) begin
        idx_r <= idx_r + 1'b1;
      end
      if (cmd.update && take_r) begin
        last_time_r <= item_r.now_ms;
        if (inrange_r && (cm != '0)) begin
          dist_r <= cm;
          str_r  <= str_new;
        end else begin
          dist_r <= '0;
          str_r  <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
    end
    if (cmd.calc) begin
      take_r    <= (elapsed >= {16'd0, period_r});
      inrange_r <= inrange;
      prod_r    <= {{(rfrd_pkg::PROD_W-rfrd_pkg::MM_W){1'b0}},
                    item_r.range_mm[rfrd_pkg::MM_W-1:0]} *
                   {{(rfrd_pkg::PROD_W-rfrd_pkg::RECIP_W){1'b0}}, rfrd_pkg::RECIP_TEN};
    end
  end

  assign burst_end = {1'b0, pointer_r} + {1'b0, item_r.read_count};
  assign byte_addr = pointer_r[1:0] + idx_r;

  always_comb begin
    case (byte_addr)
      rfrd_pkg::REG_DIST_LO: reg_data = dist_r[7:0];
      rfrd_pkg::REG_DIST_HI: reg_data = 8'(dist_r[rfrd_pkg::DIST_W-1:8]);
      rfrd_pkg::REG_STR_LO:  reg_data = str_r[7:0];
      rfrd_pkg::REG_STR_HI:  reg_data = str_r[15:8];
      default:               reg_data = '0;
    endcase
  end

  always_comb begin
    out_data = '{read_byte: 8'd0, byte_valid: 1'b0, status: 1'b1, last: 1'b1};
    case (item_r.mode)
      rfrd_pkg::MODE_SELECT: out_data.status = 1'b0;
      rfrd_pkg::MODE_READ: begin
        if (pointer_r inside {[8'd0:8'd3]}) begin
          if (burst_end > {1'b0, rfrd_pkg::BURST_REGS}) begin
            out_data.status = 1'b1;
          end else if (item_r.read_count == 8'd0) begin
            out_data.status = 1'b0;
          end else begin
            out_data.read_byte  = reg_data;
            out_data.byte_valid = 1'b1;
            out_data.status     = 1'b0;
            out_data.last       = ({6'd0, idx_r} + 8'd1) == item_r.read_count;
          end
        end else if (pointer_r == rfrd_pkg::REG_VERSION) begin
          out_data.read_byte  = rfrd_pkg::VERSION_BYTE;
          out_data.byte_valid = 1'b1;
          out_data.status     = 1'b0;
        end
      end
      default: out_data.status = 1'b1;
    endcase
  end

  assign stat.is_meas = (in_data.mode == rfrd_pkg::MODE_MEAS);
  assign stat.is_last = out_data.last;

endmodule

@@ src/rangefinder_register_device_unit.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rangefinder_register_device_unit: range sensor register device
// Stores distance and strength from timed measurements and serves byte
// register reads over a select/read word interface.
// ---------------------------------------------------------------------------
// channel  direction  handshake              payload
// in_      in         in_valid / in_ready    rfrd_pkg::in_t
// out_     out        out_valid / out_ready  rfrd_pkg::out_t
// cfg_     in         cfg_we                 cfg_index, cfg_wdata
//
// A measurement word steps through accept, compare and reciprocal multiply,
// and state update. Select, malformed and read words are accepted, then give
// n result words, one per cycle while out_ready is high; n is at most 4.
// Synchronous reset restores configuration defaults and clears sensor state and the controller.
// A stalled result holds its word and blocks the next input word.
// ---------------------------------------------------------------------------
module rangefinder_register_device_unit #(
  parameter int MAX_DISTANCE_CM = rfrd_pkg::MAX_DISTANCE_CM_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  rfrd_pkg::in_t                   in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output rfrd_pkg::out_t                  out_data,
  input  logic                            cfg_we,
  input  logic [rfrd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rfrd_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  rfrd_pkg::cmd_t  cmd;
  rfrd_pkg::stat_t stat;

  rfrd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rfrd_dp #(
    .MAX_DISTANCE_CM (MAX_DISTANCE_CM)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data)
  );

`ifndef ASSERT_OFF
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input taken while a result word is pending");

  a_burst_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_data.last) |=> out_valid)
    else $error("burst dropped before its last word");

  a_meas_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.mode == rfrd_pkg::MODE_MEAS) |=> !out_valid)
    else $error("measurement word produced a result");

  a_empty_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.byte_valid) |-> (out_data.read_byte == 8'd0))
    else $error("data byte set without byte_valid");
`endif

endmodule
